/* src/assert_macros.svh */
// Assertion macros shared by the RTL; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define G2E_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("g2e assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define G2E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("g2e assertion failed");

`endif

/* src/g2e_pkg.sv */
// Types, constants and elaboration-time functions for the geodetic to ECEF converter.
package g2e_pkg;

	localparam int unsigned G2E_CORDIC_STAGES = 32;
	localparam int unsigned G2E_ANGLE_BITS    = 32;

	localparam int unsigned G2E_ANG_W = 32;
	localparam int unsigned G2E_H_W   = 28;
	localparam int unsigned G2E_POS_W = 34;

	localparam int unsigned G2E_FRAC = 40;
	localparam int unsigned G2E_CW   = 44;
	localparam int unsigned G2E_MW   = 48;
	localparam int unsigned G2E_PW   = 58;
	localparam int unsigned G2E_NW   = 42;

	localparam logic [1:0] G2E_Q0 = 2'd0;
	localparam logic [1:0] G2E_Q1 = 2'd1;
	localparam logic [1:0] G2E_Q2 = 2'd2;
	localparam logic [1:0] G2E_Q3 = 2'd3;

	localparam logic [63:0] G2E_PI_QUARTER_Q62 = 64'h3243F6A8885A308D;
	localparam logic [63:0] G2E_INV_PI_Q64     = 64'h517CC1B727220A95;
	localparam logic [63:0] G2E_RSQRT2_Q40     = 64'hB504F333FA;
	localparam logic [63:0] G2E_INV_FLAT_NUM   = 64'd298257223563;
	localparam logic [63:0] G2E_INV_FLAT_DEN   = 64'd1000000000;
	localparam logic [63:0] G2E_SEMI_MAJOR_MM  = 64'd6378137000;
	localparam logic [63:0] G2E_ONE            = 64'd1 << G2E_FRAC;
	localparam logic [63:0] G2E_THREE          = 64'd3 << G2E_FRAC;

	localparam logic signed [G2E_PW-1:0] G2E_OUT_LIMIT = 58'sd6600000000;

	typedef struct packed {
		logic signed [G2E_CW-1:0] x;
		logic signed [G2E_CW-1:0] y;
		logic [1:0]               q;
	} g2e_rot_t;

	// round(a*b / 2^f), kept to 64 bits
	function automatic logic [63:0] g2e_mulq(input logic [63:0] a, input logic [63:0] b,
			input int unsigned f);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (f - 1));
		return p[f +: 64];
	endfunction

	// restoring division, used at elaboration only
	function automatic logic [63:0] g2e_udiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in units of 2^-ab turn
	function automatic logic [63:0] g2e_atan(input int unsigned i, input int unsigned ab);
		logic [63:0] rad;
		logic [63:0] t;
		rad = '0;
		if (i == 0) begin
			rad = G2E_PI_QUARTER_Q62;
		end else begin
			for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
				t = g2e_udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
				rad = k[0] ? rad - t : rad + t;
			end
		end
		t = g2e_mulq(rad, G2E_INV_PI_Q64, 64);
		return (t + (64'd1 << (62 - ab))) >> (63 - ab);
	endfunction

	function automatic logic [63:0] g2e_rsqrt(input logic [63:0] v);
		logic [63:0] y;
		logic [63:0] t;
		y = G2E_ONE;
		for (int n = 0; n < 6; n++) begin
			t = g2e_mulq(v, g2e_mulq(y, y, G2E_FRAC), G2E_FRAC);
			if (t > G2E_THREE)
				t = G2E_THREE;
			y = g2e_mulq(y, G2E_THREE - t, G2E_FRAC + 1);
		end
		return y;
	endfunction

	function automatic logic [63:0] g2e_gain(input int unsigned stages);
		logic [63:0] p;
		p = 64'd1 << 61;
		for (int unsigned i = 0; i < stages; i++)
			if (2 * i < 64)
				p = p + (p >> (2 * i));
		return g2e_mulq(g2e_rsqrt(p >> 22), G2E_RSQRT2_Q40, G2E_FRAC);
	endfunction

	function automatic logic [63:0] g2e_ecc_sq();
		logic [63:0] r;
		logic [63:0] f;
		logic [63:0] e2;
		r = G2E_INV_FLAT_DEN;
		f = '0;
		for (int n = 0; n < 60; n++) begin
			r = r << 1;
			f = f << 1;
			if (r >= G2E_INV_FLAT_NUM) begin
				r = r - G2E_INV_FLAT_NUM;
				f = f | 64'd1;
			end
		end
		e2 = 2 * f - g2e_mulq(f, f, 60);
		return (e2 + (64'd1 << 19)) >> 20;
	endfunction

	localparam logic [63:0] G2E_E2       = g2e_ecc_sq();
	localparam logic [63:0] G2E_ONE_M_E2 = G2E_ONE - G2E_E2;

	function automatic logic [G2E_MW-1:0] g2e_cmag(input logic signed [G2E_CW-1:0] v);
		logic [G2E_CW-1:0] m;
		m = v[G2E_CW-1] ? $unsigned(-v) : $unsigned(v);
		return G2E_MW'(m);
	endfunction

	function automatic logic [G2E_MW-1:0] g2e_pmag(input logic signed [G2E_PW-1:0] v);
		logic [G2E_PW-1:0] m;
		m = v[G2E_PW-1] ? $unsigned(-v) : $unsigned(v);
		return m[G2E_MW-1:0];
	endfunction

	function automatic logic signed [G2E_POS_W-1:0] g2e_clamp(
			input logic signed [G2E_PW-1:0] v);
		logic signed [G2E_PW-1:0] c;
		c = v;
		if (v > G2E_OUT_LIMIT)
			c = G2E_OUT_LIMIT;
		else if (v < -G2E_OUT_LIMIT)
			c = -G2E_OUT_LIMIT;
		return c[G2E_POS_W-1:0];
	endfunction

endpackage

/* src/g2e_in_if.sv */
// Input channel: one geodetic point per transfer.
interface g2e_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [g2e_pkg::G2E_ANG_W-1:0]   longitude;
	logic signed [g2e_pkg::G2E_ANG_W-1:0]   latitude;
	logic signed [g2e_pkg::G2E_H_W-1:0]     height;

	modport source (output valid, output longitude, output latitude, output height,
		input ready);
	modport sink (input valid, input longitude, input latitude, input height,
		output ready);
endinterface

/* src/g2e_out_if.sv */
// Output channel: one ECEF position per transfer.
interface g2e_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [g2e_pkg::G2E_POS_W-1:0] pos_x;
	logic signed [g2e_pkg::G2E_POS_W-1:0] pos_y;
	logic signed [g2e_pkg::G2E_POS_W-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

/* src/g2e_mul.sv */
// Two-stage rounding multiplier built from four half-width partial products.
module g2e_mul #(
	parameter int unsigned SHIFT = g2e_pkg::G2E_FRAC
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [g2e_pkg::G2E_MW-1:0]         a,
	input  logic [g2e_pkg::G2E_MW-1:0]         b,
	input  logic                               neg,
	output logic signed [g2e_pkg::G2E_PW-1:0]  p
);
	import g2e_pkg::*;

	localparam int unsigned HW = G2E_MW / 2;
	localparam int unsigned SW = 2 * G2E_MW + 8;

	logic [2*HW-1:0]         ll_s1, lh_s1, hl_s1, hh_s1;
	logic                    neg_s1;
	logic [SW-1:0]           sum;
	logic [G2E_PW-1:0]       mag;
	logic signed [G2E_PW-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= a[HW-1:0] * b[HW-1:0];
			lh_s1  <= a[HW-1:0] * b[2*HW-1:HW];
			hl_s1  <= a[2*HW-1:HW] * b[HW-1:0];
			hh_s1  <= a[2*HW-1:HW] * b[2*HW-1:HW];
			neg_s1 <= neg;
		end
	end

	// round half up on the magnitude, so negated results tie away from zero
	always_comb begin
		sum = SW'(ll_s1) + (SW'(lh_s1) << HW) + (SW'(hl_s1) << HW) + (SW'(hh_s1) << (2 * HW))
			+ (SW'(1) << (SHIFT - 1));
		mag = sum[SHIFT +: G2E_PW];
	end

	always_ff @(posedge clk) begin
		if (en)
			p_s2 <= neg_s1 ? -$signed(mag) : $signed(mag);
	end

	assign p = p_s2;

endmodule

/* src/g2e_cordic_cell.sv */
// One rotation-mode CORDIC cell: a fixed micro-rotation and a register.
module g2e_cordic_cell #(
	parameter int unsigned ANGLE_BITS = g2e_pkg::G2E_ANGLE_BITS,
	parameter int unsigned IDX        = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  g2e_pkg::g2e_rot_t             rot_in,
	input  logic signed [ANGLE_BITS-1:0]  z_in,
	output g2e_pkg::g2e_rot_t             rot_out,
	output logic signed [ANGLE_BITS-1:0]  z_out
);
	import g2e_pkg::*;

	localparam logic signed [ANGLE_BITS-1:0] ATAN = ANGLE_BITS'(g2e_atan(IDX, ANGLE_BITS));

	g2e_rot_t                    rot_q;
	logic signed [ANGLE_BITS-1:0] z_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q.q <= rot_in.q;
			if (!z_in[ANGLE_BITS-1]) begin
				rot_q.x <= rot_in.x - (rot_in.y >>> IDX);
				rot_q.y <= rot_in.y + (rot_in.x >>> IDX);
				z_q     <= z_in - ATAN;
			end else begin
				rot_q.x <= rot_in.x + (rot_in.y >>> IDX);
				rot_q.y <= rot_in.y - (rot_in.x >>> IDX);
				z_q     <= z_in + ATAN;
			end
		end
	end

	assign rot_out = rot_q;
	assign z_out   = z_q;

endmodule

/* src/g2e_newton_cell.sv */
// One Newton step of 1/sqrt(v): y' = y(3 - v y^2)/2, three multiplies deep.
module g2e_newton_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [g2e_pkg::G2E_NW-1:0]  v_in,
	input  logic [g2e_pkg::G2E_NW-1:0]  y_in,
	output logic [g2e_pkg::G2E_NW-1:0]  v_out,
	output logic [g2e_pkg::G2E_NW-1:0]  y_out
);
	import g2e_pkg::*;

	logic [G2E_NW-1:0]        vd_q [6];
	logic [G2E_NW-1:0]        yd_q [4];
	logic signed [G2E_PW-1:0] yy_p, t_p, yn_p;
	logic [G2E_PW-1:0]        t_c;
	logic [G2E_MW-1:0]        diff;

	always_ff @(posedge clk) begin
		if (en) begin
			vd_q[0] <= v_in;
			yd_q[0] <= y_in;
			for (int k = 1; k < 6; k++)
				vd_q[k] <= vd_q[k-1];
			for (int k = 1; k < 4; k++)
				yd_q[k] <= yd_q[k-1];
		end
	end

	g2e_mul #(.SHIFT(G2E_FRAC)) u_sq (
		.clk (clk), .en (en), .a (G2E_MW'(y_in)), .b (G2E_MW'(y_in)), .neg (1'b0),
		.p (yy_p)
	);

	g2e_mul #(.SHIFT(G2E_FRAC)) u_vyy (
		.clk (clk), .en (en), .a (G2E_MW'(vd_q[1])), .b (yy_p[G2E_MW-1:0]), .neg (1'b0),
		.p (t_p)
	);

	// clamp v*y^2 at three
	always_comb begin
		t_c = $unsigned(t_p);
		if (t_c > G2E_PW'(G2E_THREE))
			t_c = G2E_PW'(G2E_THREE);
		diff = G2E_MW'(G2E_THREE) - t_c[G2E_MW-1:0];
	end

	g2e_mul #(.SHIFT(G2E_FRAC + 1)) u_upd (
		.clk (clk), .en (en), .a (G2E_MW'(yd_q[3])), .b (diff), .neg (1'b0),
		.p (yn_p)
	);

	assign v_out = vd_q[5];
	assign y_out = yn_p[G2E_NW-1:0];

endmodule

/* src/geodetic_to_ecef.sv */
// Top level: WGS84 geodetic point to Earth-centred coordinates, fully pipelined.
//
//   channel | dir | fields                          | transfer when
//   geo     | in  | longitude, latitude, height     | geo.valid & geo.ready
//   ecef    | out | pos_x, pos_y, pos_z             | ecef.valid & ecef.ready
//
// One point enters per cycle while no result waits untaken at the output; the delay is set by the CORDIC
// cell chain, six three-multiply Newton cells and the final product chain.
// Each multiplier splits into half-width partial products and is itself pipelined.
// The whole pipeline holds while a result waits at the output; bubbles move on otherwise.
// Reset clears the valid bits only.
`include "assert_macros.svh"

module geodetic_to_ecef #(
	parameter int unsigned CORDIC_STAGES = g2e_pkg::G2E_CORDIC_STAGES,
	parameter int unsigned ANGLE_BITS    = g2e_pkg::G2E_ANGLE_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	g2e_in_if.sink       geo,
	g2e_out_if.source    ecef
);
	import g2e_pkg::*;

	localparam int unsigned TW   = G2E_ANG_W + ANGLE_BITS;
	localparam int unsigned S    = CORDIC_STAGES;
	localparam int unsigned VL   = S + 49;
	localparam int unsigned HDEP = S + 45;
	localparam logic [63:0] GAIN = g2e_gain(CORDIC_STAGES);

	logic            adv;
	logic [VL-1:0]   v_q;

	logic [TW-1:0]   lon_t, lat_t;
	logic [ANGLE_BITS-1:0] lon_a, lat_a;

	g2e_rot_t                     lon_s0, lat_s0;
	logic signed [ANGLE_BITS-1:0] lonz_s0, latz_s0;
	logic signed [G2E_H_W-1:0]    h_s0;

	g2e_rot_t                     lon_r [S+1];
	g2e_rot_t                     lat_r [S+1];
	logic signed [ANGLE_BITS-1:0] lon_z [S+1];
	logic signed [ANGLE_BITS-1:0] lat_z [S+1];

	logic signed [G2E_CW-1:0] cl_f, sl_f, cb_f, sb_f;
	logic signed [G2E_CW-1:0] cl_n, sl_n, cb_n, sb_n;

	logic signed [G2E_PW-1:0] sq_p, xc_p, yc_p, esb_p, n_p, nz_p, x_p, y_p, z_p;

	logic [G2E_NW-1:0] nv [7];
	logic [G2E_NW-1:0] ny [7];

	logic signed [G2E_H_W-1:0]  hd_q  [HDEP];
	logic signed [G2E_CW-1:0]   sbd_q [44];
	logic signed [G2E_PW-1:0]   xcd_q [42];
	logic signed [G2E_PW-1:0]   ycd_q [42];
	logic signed [G2E_PW-1:0]   rd_q  [2];
	logic signed [G2E_PW-1:0]   r_n, zr_n;

	logic signed [G2E_POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;

	// hold everything while the output register is full and not taken
	assign adv       = !v_q[VL-1] || ecef.ready;
	assign geo.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[VL-2:0], geo.valid};
		end
	end

	// binary angle to ANGLE_BITS per turn, round half up, wrap
	always_comb begin
		lon_t = {geo.longitude, {ANGLE_BITS{1'b0}}} + (TW'(1) << (G2E_ANG_W - 1));
		lat_t = {geo.latitude, {ANGLE_BITS{1'b0}}} + (TW'(1) << (G2E_ANG_W - 1));
		lon_a = lon_t[TW-1:G2E_ANG_W];
		lat_a = lat_t[TW-1:G2E_ANG_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lon_s0.x <= G2E_CW'(GAIN);
			lon_s0.y <= '0;
			lon_s0.q <= lon_a[ANGLE_BITS-1:ANGLE_BITS-2];
			lonz_s0  <= {2'b00, lon_a[ANGLE_BITS-3:0]};
			lat_s0.x <= G2E_CW'(GAIN);
			lat_s0.y <= '0;
			lat_s0.q <= lat_a[ANGLE_BITS-1:ANGLE_BITS-2];
			latz_s0  <= {2'b00, lat_a[ANGLE_BITS-3:0]};
			h_s0     <= geo.height;
		end
	end

	assign lon_r[0] = lon_s0;
	assign lat_r[0] = lat_s0;
	assign lon_z[0] = lonz_s0;
	assign lat_z[0] = latz_s0;

	for (genvar g = 0; g < S; g++) begin : g_cordic
		g2e_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .IDX(g)) u_lon (
			.clk (clk), .en (adv), .rot_in (lon_r[g]), .z_in (lon_z[g]),
			.rot_out (lon_r[g+1]), .z_out (lon_z[g+1])
		);
		g2e_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .IDX(g)) u_lat (
			.clk (clk), .en (adv), .rot_in (lat_r[g]), .z_in (lat_z[g]),
			.rot_out (lat_r[g+1]), .z_out (lat_z[g+1])
		);
	end

	// swap and negate by quadrant
	always_comb begin
		unique case (lon_r[S].q)
			G2E_Q0: begin cl_n = lon_r[S].x;  sl_n = lon_r[S].y;  end
			G2E_Q1: begin cl_n = -lon_r[S].y; sl_n = lon_r[S].x;  end
			G2E_Q2: begin cl_n = -lon_r[S].x; sl_n = -lon_r[S].y; end
			G2E_Q3: begin cl_n = lon_r[S].y;  sl_n = -lon_r[S].x; end
			default: begin cl_n = lon_r[S].x; sl_n = lon_r[S].y;  end
		endcase
		unique case (lat_r[S].q)
			G2E_Q0: begin cb_n = lat_r[S].x;  sb_n = lat_r[S].y;  end
			G2E_Q1: begin cb_n = -lat_r[S].y; sb_n = lat_r[S].x;  end
			G2E_Q2: begin cb_n = -lat_r[S].x; sb_n = -lat_r[S].y; end
			G2E_Q3: begin cb_n = lat_r[S].y;  sb_n = -lat_r[S].x; end
			default: begin cb_n = lat_r[S].x; sb_n = lat_r[S].y;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cl_f <= cl_n;
			sl_f <= sl_n;
			cb_f <= cb_n;
			sb_f <= sb_n;
		end
	end

	g2e_mul #(.SHIFT(G2E_FRAC)) u_sq (
		.clk (clk), .en (adv), .a (g2e_cmag(sb_f)), .b (g2e_cmag(sb_f)), .neg (1'b0),
		.p (sq_p)
	);
	g2e_mul #(.SHIFT(G2E_FRAC)) u_xc (
		.clk (clk), .en (adv), .a (g2e_cmag(cb_f)), .b (g2e_cmag(cl_f)),
		.neg (cb_f[G2E_CW-1] ^ cl_f[G2E_CW-1]), .p (xc_p)
	);
	g2e_mul #(.SHIFT(G2E_FRAC)) u_yc (
		.clk (clk), .en (adv), .a (g2e_cmag(cb_f)), .b (g2e_cmag(sl_f)),
		.neg (cb_f[G2E_CW-1] ^ sl_f[G2E_CW-1]), .p (yc_p)
	);

	g2e_mul #(.SHIFT(G2E_FRAC)) u_esb (
		.clk (clk), .en (adv), .a (G2E_MW'(G2E_E2)), .b (sq_p[G2E_MW-1:0]), .neg (1'b0),
		.p (esb_p)
	);

	assign nv[0] = G2E_NW'(G2E_ONE) - esb_p[G2E_NW-1:0];
	assign ny[0] = G2E_NW'(G2E_ONE);

	for (genvar g = 0; g < 6; g++) begin : g_newton
		g2e_newton_cell u_cell (
			.clk (clk), .en (adv), .v_in (nv[g]), .y_in (ny[g]),
			.v_out (nv[g+1]), .y_out (ny[g+1])
		);
	end

	g2e_mul #(.SHIFT(G2E_FRAC)) u_n (
		.clk (clk), .en (adv), .a (G2E_MW'(G2E_SEMI_MAJOR_MM)), .b (G2E_MW'(ny[6])),
		.neg (1'b0), .p (n_p)
	);

	g2e_mul #(.SHIFT(G2E_FRAC)) u_nz (
		.clk (clk), .en (adv), .a (n_p[G2E_MW-1:0]), .b (G2E_MW'(G2E_ONE_M_E2)),
		.neg (1'b0), .p (nz_p)
	);

	// side data delayed to meet the product chain
	always_ff @(posedge clk) begin
		if (adv) begin
			hd_q[0]  <= h_s0;
			sbd_q[0] <= sb_f;
			xcd_q[0] <= xc_p;
			ycd_q[0] <= yc_p;
			rd_q[0]  <= r_n;
			rd_q[1]  <= rd_q[0];
			for (int k = 1; k < HDEP; k++)
				hd_q[k] <= hd_q[k-1];
			for (int k = 1; k < 44; k++)
				sbd_q[k] <= sbd_q[k-1];
			for (int k = 1; k < 42; k++) begin
				xcd_q[k] <= xcd_q[k-1];
				ycd_q[k] <= ycd_q[k-1];
			end
		end
	end

	assign r_n  = n_p + G2E_PW'(hd_q[S+42]);
	assign zr_n = nz_p + G2E_PW'(hd_q[S+44]);

	g2e_mul #(.SHIFT(G2E_FRAC)) u_x (
		.clk (clk), .en (adv), .a (g2e_pmag(rd_q[1])), .b (g2e_pmag(xcd_q[41])),
		.neg (rd_q[1][G2E_PW-1] ^ xcd_q[41][G2E_PW-1]), .p (x_p)
	);
	g2e_mul #(.SHIFT(G2E_FRAC)) u_y (
		.clk (clk), .en (adv), .a (g2e_pmag(rd_q[1])), .b (g2e_pmag(ycd_q[41])),
		.neg (rd_q[1][G2E_PW-1] ^ ycd_q[41][G2E_PW-1]), .p (y_p)
	);
	g2e_mul #(.SHIFT(G2E_FRAC)) u_z (
		.clk (clk), .en (adv), .a (g2e_pmag(zr_n)), .b (g2e_cmag(sbd_q[43])),
		.neg (zr_n[G2E_PW-1] ^ sbd_q[43][G2E_CW-1]), .p (z_p)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x_q <= g2e_clamp(x_p);
			pos_y_q <= g2e_clamp(y_p);
			pos_z_q <= g2e_clamp(z_p);
		end
	end

	assign ecef.valid = v_q[VL-1];
	assign ecef.pos_x = pos_x_q;
	assign ecef.pos_y = pos_y_q;
	assign ecef.pos_z = pos_z_q;

	`G2E_ASSERT_IMPLY(a_x_range, ecef.valid, (ecef.pos_x <= G2E_OUT_LIMIT) && (ecef.pos_x >= -G2E_OUT_LIMIT))
	`G2E_ASSERT_IMPLY(a_z_range, ecef.valid, (ecef.pos_z <= G2E_OUT_LIMIT) && (ecef.pos_z >= -G2E_OUT_LIMIT))
	`G2E_ASSERT_NEXT(a_stall_hold, !adv, $stable(v_q))

endmodule
